// ===== sv/aets_pkg.sv =====
// Shared constants, result codes and the decoded event type of the event time surface.
package aets_pkg;

	localparam int SENSOR_SIZE = 128;
	localparam int MAP_AW      = 15;
	localparam int MAP_DEPTH   = 1 << MAP_AW;

	localparam logic [31:0] WRAP_STEP = 32'h0000_4000;
	localparam logic signed [7:0] RESPONSE = 8'sd127;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_WRAP   = 2'd1;
	localparam logic [1:0] KIND_ORESET = 2'd2;
	localparam logic [1:0] KIND_READ   = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [6:0]        x;
		logic [6:0]        y;
		logic signed [7:0] pol;
		logic              cam;
		logic [31:0]       t;
	} dec_t;

endpackage

// ===== sv/aets_decode.sv =====
// Decoder of one address-event word into kind, coordinates, polarity, camera and time.
module aets_decode import aets_pkg::*; (
	input  logic        format_mode,
	input  logic [31:0] wrap_offset,
	input  logic [31:0] event_word,
	input  logic [31:0] time_word,
	output dec_t        dec
);

	logic [15:0] addr;
	logic [7:0]  raw_y;
	logic [7:0]  flip_x;
	logic [7:0]  flip_y;

	assign addr   = event_word[15:0];
	assign raw_y  = 8'(SENSOR_SIZE - 1) - {1'b0, addr[7:1]};
	assign flip_y = 8'(SENSOR_SIZE) - raw_y;
	assign flip_x = 8'(SENSOR_SIZE) - {1'b0, addr[14:8]};

	always_comb begin
		dec = '0;
		if (!format_mode && event_word[31]) begin
			dec.kind = KIND_WRAP;
		end else if (!format_mode && event_word[30]) begin
			dec.kind = KIND_ORESET;
		end else begin
			dec.kind = KIND_PIXEL;
			dec.x    = flip_x[6:0];
			dec.y    = flip_y[6:0];
			dec.pol  = addr[0] ? 8'sd1 : -8'sd1;
			// Four-byte words always come from the left camera.
			dec.cam  = format_mode ? ~addr[15] : 1'b1;
			dec.t    = format_mode ? time_word : ({16'b0, event_word[31:16]} + wrap_offset);
		end
	end

endmodule

// ===== sv/aer_event_time_surface.sv =====
// Top level of the address-event decoder with per-camera polarity and time maps.
//
// An item is taken at a rising edge with start high and busy low. It is either an event
// word (req_type 0) or a read of one map entry (req_type 1). Every item gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall it.
// Wrap and offset reset words give their result in the cycle after the edge that took
// them, and busy stays low, so they can come one per cycle.
// Pixel events and reads go through the map memories: the entry is read into a register
// at the accept edge, then compared and written back in ST_EXEC, and the result shows
// when ST_EXEC ends. busy is high from the accept edge until then, so such an item is not
// taken before the last one is through; a clear sweep may come before ST_EXEC.
// A pixel event with clear_times set first sweeps the time map, one entry a cycle, with
// busy high. After reset both maps are cleared by a like sweep in ST_INIT, busy high.
// The user writes the format register with cfg_wr_en only while the block is idle;
// the block itself does not enforce it.
module aer_event_time_surface import aets_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [31:0]        event_word,
	input  logic [31:0]        time_word,
	input  logic               clear_times,
	input  logic               read_camera,
	input  logic [6:0]         read_x,
	input  logic [6:0]         read_y,
	output logic               done,
	output logic [1:0]         kind,
	output logic [6:0]         pixel_x,
	output logic [6:0]         pixel_y,
	output logic signed [7:0]  polarity,
	output logic               camera,
	output logic [31:0]        event_time,
	output logic               map_written,
	output logic [31:0]        last_time_left,
	output logic [31:0]        last_time_right,
	output logic               seen_left,
	output logic               seen_right
);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	logic [1:0]        state_q;
	logic [MAP_AW-1:0] sweep_q;
	logic              format_q;
	logic [31:0]       wrap_q;
	logic [31:0]       left_last_q;
	logic [31:0]       right_last_q;
	logic              left_seen_q;
	logic              right_seen_q;

	dec_t              dec;
	dec_t              req_q;
	logic              clr_q;
	logic [MAP_AW-1:0] idx_q;
	logic [MAP_AW-1:0] rd_idx;
	logic              accept;
	logic              sweep_last;

	logic [31:0]       time_mem [0:MAP_DEPTH-1];
	logic signed [7:0] pol_mem [0:MAP_DEPTH-1];
	logic [31:0]       time_rd_q;
	logic signed [7:0] pol_rd_q;

	logic [31:0]       cur_time;
	logic              upd;
	logic              time_we;
	logic [MAP_AW-1:0] time_wa;
	logic [31:0]       time_wd;
	logic              pol_we;
	logic [MAP_AW-1:0] pol_wa;
	logic signed [7:0] pol_wd;

	logic              done_q;
	logic [1:0]        kind_q;
	logic [6:0]        x_q;
	logic [6:0]        y_q;
	logic signed [7:0] pol_q;
	logic              cam_q;
	logic [31:0]       t_q;
	logic              wr_q;

	aets_decode u_decode (
		.format_mode (format_q),
		.wrap_offset (wrap_q),
		.event_word  (event_word),
		.time_word   (time_word),
		.dec         (dec)
	);

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign sweep_last = (sweep_q == {MAP_AW{1'b1}});
	assign rd_idx     = req_type ? {read_camera, read_y, read_x} : {dec.cam, dec.y, dec.x};

	// After a clear sweep the entry is known to be zero.
	assign cur_time = clr_q ? 32'd0 : time_rd_q;
	assign upd      = (req_q.kind == KIND_PIXEL) && (cur_time < req_q.t);

	always_comb begin
		time_we = 1'b0;
		time_wa = idx_q;
		time_wd = req_q.t;
		pol_we  = 1'b0;
		pol_wa  = idx_q;
		pol_wd  = (req_q.pol == 8'sd1) ? RESPONSE : -RESPONSE;
		case (state_q)
			ST_INIT: begin
				time_we = 1'b1;
				time_wa = sweep_q;
				time_wd = '0;
				pol_we  = 1'b1;
				pol_wa  = sweep_q;
				pol_wd  = '0;
			end
			ST_CLEAR: begin
				time_we = 1'b1;
				time_wa = sweep_q;
				time_wd = '0;
			end
			ST_EXEC: begin
				time_we = upd;
				pol_we  = upd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (time_we) begin
			time_mem[time_wa] <= time_wd;
		end
		if (accept) begin
			time_rd_q <= time_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (pol_we) begin
			pol_mem[pol_wa] <= pol_wd;
		end
		if (accept) begin
			pol_rd_q <= pol_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= 1'b0;
		end else if (cfg_wr_en) begin
			format_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sweep_q      <= '0;
			wrap_q       <= '0;
			left_last_q  <= '0;
			right_last_q <= '0;
			left_seen_q  <= 1'b0;
			right_seen_q <= 1'b0;
			done_q       <= 1'b0;
			clr_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req_type) begin
							clr_q   <= 1'b0;
							state_q <= ST_EXEC;
						end else if (dec.kind == KIND_WRAP) begin
							wrap_q <= wrap_q + WRAP_STEP;
							done_q <= 1'b1;
						end else if (dec.kind == KIND_ORESET) begin
							wrap_q <= '0;
							done_q <= 1'b1;
						end else begin
							clr_q   <= clear_times;
							state_q <= clear_times ? ST_CLEAR : ST_EXEC;
						end
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (req_q.kind == KIND_PIXEL) begin
						if (req_q.x != '0 && req_q.y != '0 && req_q.t != '0) begin
							if (req_q.cam) begin
								left_seen_q <= 1'b1;
							end else begin
								right_seen_q <= 1'b1;
							end
						end
						if (req_q.cam) begin
							left_last_q <= req_q.t;
						end else if (clr_q) begin
							right_last_q <= '0;
						end else if (req_q.t > right_last_q) begin
							right_last_q <= req_q.t;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (req_type) begin
				req_q.kind <= KIND_READ;
				req_q.x    <= read_x;
				req_q.y    <= read_y;
				req_q.pol  <= '0;
				req_q.cam  <= read_camera;
				req_q.t    <= '0;
			end else begin
				req_q <= dec;
			end
			idx_q <= rd_idx;
			kind_q <= dec.kind;
			x_q    <= '0;
			y_q    <= '0;
			pol_q  <= '0;
			cam_q  <= 1'b0;
			t_q    <= '0;
			wr_q   <= 1'b0;
		end else if (state_q == ST_EXEC) begin
			kind_q <= req_q.kind;
			x_q    <= req_q.x;
			y_q    <= req_q.y;
			cam_q  <= req_q.cam;
			if (req_q.kind == KIND_READ) begin
				pol_q <= pol_rd_q;
				t_q   <= time_rd_q;
				wr_q  <= 1'b0;
			end else begin
				pol_q <= req_q.pol;
				t_q   <= req_q.t;
				wr_q  <= upd;
			end
		end
	end

	assign done            = done_q;
	assign kind            = kind_q;
	assign pixel_x         = x_q;
	assign pixel_y         = y_q;
	assign polarity        = pol_q;
	assign camera          = cam_q;
	assign event_time      = t_q;
	assign map_written     = wr_q;
	assign last_time_left  = left_last_q;
	assign last_time_right = right_last_q;
	assign seen_left       = left_seen_q;
	assign seen_right      = right_seen_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q == ST_EXEC) || $past(accept)))
		else $error("result strobe without a finished item");

	a_written_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && map_written) |-> (kind == KIND_PIXEL))
		else $error("map write flagged on a result that is not a pixel event");

	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && sweep_last) |=> (state_q == ST_EXEC && clr_q))
		else $error("clear sweep did not hand over to the pending event");

	a_exec_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> (state_q == ST_IDLE && done))
		else $error("map update took more than one cycle");

	a_no_accept_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_CLEAR) |-> (busy && !time_we == 1'b0))
		else $error("item could be taken during a memory sweep");

endmodule
